// ----- sv/fchd_pkg.sv -----
// fchd_pkg: shared types, constants and crc function for the frame header decoder
// no dependencies
package fchd_pkg;

    localparam int HEADER_BYTES_DEF    = 32;
    localparam int CHECKSUM_OFFSET_DEF = 28;
    localparam int COUNT_W             = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [31:0] MAGIC_WORD = 32'h3143_5649; // bytes 0..3 little-endian
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [2:0] REG_VERSION    = 3'd0;
    localparam logic [2:0] REG_FLAGS_MASK = 3'd1;
    localparam logic [2:0] REG_MAX_PLEN   = 3'd2;
    localparam logic [2:0] REG_MIN_TYPE   = 3'd3;
    localparam logic [2:0] REG_MAX_TYPE   = 3'd4;
    localparam logic [2:0] REG_ERR_TYPE   = 3'd5;
    localparam logic [2:0] REG_MAX_ECODE  = 3'd6;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_SHORT    = 4'd1;
    localparam logic [3:0] ST_MAGIC    = 4'd2;
    localparam logic [3:0] ST_VERSION  = 4'd3;
    localparam logic [3:0] ST_TYPE     = 4'd4;
    localparam logic [3:0] ST_FLAGS    = 4'd5;
    localparam logic [3:0] ST_LARGE    = 4'd6;
    localparam logic [3:0] ST_LENGTH   = 4'd7;
    localparam logic [3:0] ST_ECODE    = 4'd8;
    localparam logic [3:0] ST_CHECKSUM = 4'd9;

    localparam logic [1:0] RJ_VERSION  = 2'd0;
    localparam logic [1:0] RJ_CHECKSUM = 2'd1;
    localparam logic [1:0] RJ_MALFORM  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  msg_kind;
        logic [15:0] flag_bits;
        logic [31:0] sess_ident;
        logic [31:0] sequence_number;
        logic [63:0] stamp_usec;
        logic [15:0] body_len;
        logic [15:0] fault_code;
        logic        reject_valid;
        logic [1:0]  reject_error;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  protocol_version;
        logic [15:0] valid_flags_mask;
        logic [15:0] max_body_len;
        logic [7:0]  min_msg_kind;
        logic [7:0]  max_msg_kind;
        logic [7:0]  fault_msg_kind;
        logic [15:0] max_fault_code;
    } t_cfg;

    // closed frame handed from front to back
    typedef struct packed {
        logic [COUNT_W-1:0] len;
        logic [31:0]        crc;
        logic [255:0]       hdr;
    } t_frame;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

// ----- sv/frame_crc_header_decoder_top.sv -----
// frame header decoder top: one byte per cycle unless stalled, one result per frame
// path: last byte to result valid passes the queue register, then the output register
// throughput: one byte per cycle while the queue is not full; the queue holds two closed frames
// reset: i_rst_n synchronous active low clears counters, crc, queue and config
// depends on fchd_pkg, fchd_front, fchd_queue, fchd_back
module frame_crc_header_decoder_top import fchd_pkg::*; #(
    parameter int HEADER_BYTES    = HEADER_BYTES_DEF,
    parameter int CHECKSUM_OFFSET = CHECKSUM_OFFSET_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_item    i_item,
    output logic        o_stall,
    output logic        o_valid,
    output t_out_item   o_item,
    input  logic        i_stall,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    t_cfg   r_cfg;
    t_frame front_frame, queue_frame;
    logic   push, full, avail, pop;

    // config writes always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.protocol_version <= 8'd1;
            r_cfg.valid_flags_mask <= 16'd1;
            r_cfg.max_body_len     <= 16'd1024;
            r_cfg.min_msg_kind     <= 8'd1;
            r_cfg.max_msg_kind     <= 8'd8;
            r_cfg.fault_msg_kind   <= 8'd4;
            r_cfg.max_fault_code   <= 16'd16;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_VERSION:    r_cfg.protocol_version <= i_cfg_data[7:0];
                REG_FLAGS_MASK: r_cfg.valid_flags_mask <= i_cfg_data;
                REG_MAX_PLEN:   r_cfg.max_body_len     <= i_cfg_data;
                REG_MIN_TYPE:   r_cfg.min_msg_kind     <= i_cfg_data[7:0];
                REG_MAX_TYPE:   r_cfg.max_msg_kind     <= i_cfg_data[7:0];
                REG_ERR_TYPE:   r_cfg.fault_msg_kind   <= i_cfg_data[7:0];
                REG_MAX_ECODE:  r_cfg.max_fault_code   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: count, capture, crc; stalls only when the queue is full
    fchd_front #(.HEADER_BYTES(HEADER_BYTES), .CHECKSUM_OFFSET(CHECKSUM_OFFSET)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_item(i_item),
        .o_stall(o_stall), .o_push(push), .o_frame(front_frame), .i_full(full)
    );

    fchd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_frame(front_frame),
        .o_full(full), .o_avail(avail), .o_frame(queue_frame), .i_pop(pop)
    );

    // back: checks and result register
    fchd_back #(.HEADER_BYTES(HEADER_BYTES), .CHECKSUM_OFFSET(CHECKSUM_OFFSET)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_avail(avail),
        .i_frame(queue_frame), .o_pop(pop), .o_valid(o_valid), .o_item(o_item),
        .i_stall(i_stall)
    );
endmodule

// ----- sv/fchd_front.sv -----
// fchd_front: byte counting, header capture and running crc
// depends on fchd_pkg
module fchd_front import fchd_pkg::*; #(
    parameter int HEADER_BYTES    = HEADER_BYTES_DEF,
    parameter int CHECKSUM_OFFSET = CHECKSUM_OFFSET_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_stall,
    output logic     o_push,
    output t_frame   o_frame,
    input  logic     i_full
);
    localparam int IDX_W = $clog2(HEADER_BYTES);

    logic [COUNT_W-1:0] r_count, n_count;
    logic [31:0]        r_crc, n_crc;
    logic [7:0]         r_hdr [HEADER_BYTES];
    logic               accept, in_hdr, in_sum;
    logic [7:0]         crc_in;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign in_hdr  = r_count < COUNT_W'(HEADER_BYTES);
    assign in_sum  = (r_count >= COUNT_W'(CHECKSUM_OFFSET)) &&
                     (r_count < COUNT_W'(CHECKSUM_OFFSET + 4));
    assign crc_in  = in_sum ? 8'd0 : i_item.data_byte;
    assign n_crc   = crc_byte(r_crc, crc_in);
    assign n_count = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else if (accept) begin
            if (i_item.last_byte) begin
                r_count <= '0;
                r_crc   <= CRC_INIT;
            end else begin
                r_count <= n_count;
                r_crc   <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_hdr) begin
            r_hdr[r_count[IDX_W-1:0]] <= i_item.data_byte;
        end
    end

    // the last byte may itself be a header byte, so merge it in
    always_comb begin
        o_frame.len = n_count;
        o_frame.crc = ~n_crc;
        o_frame.hdr = '0;
        for (int k = 0; k < 32; k++) begin
            if (k < HEADER_BYTES) begin
                o_frame.hdr[8*k +: 8] = (in_hdr && r_count[IDX_W-1:0] == IDX_W'(k)) ?
                                        i_item.data_byte : r_hdr[k];
            end
        end
    end

    assign o_push = accept && i_item.last_byte;
endmodule

// ----- sv/fchd_queue.sv -----
// fchd_queue: short fifo of closed frames between front and back
// depends on fchd_pkg
module fchd_queue import fchd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    output logic   o_full,
    output logic   o_avail,
    output t_frame o_frame,
    input  logic   i_pop
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_frame             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [PTR_W:0]     r_cnt;

    assign o_full  = r_cnt == (PTR_W+1)'(QUEUE_DEPTH);
    assign o_avail = r_cnt != '0;
    assign o_frame = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end
endmodule

// ----- sv/fchd_back.sv -----
// fchd_back: header checks, field decode and output register
// depends on fchd_pkg
module fchd_back import fchd_pkg::*; #(
    parameter int HEADER_BYTES    = HEADER_BYTES_DEF,
    parameter int CHECKSUM_OFFSET = CHECKSUM_OFFSET_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_avail,
    input  t_frame    i_frame,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);
    logic      r_valid;
    t_out_item r_item, n_item;
    logic [255:0] h;
    logic magic_ok, type_ok, ecode_bad;
    logic [31:0] sum;
    logic [17:0] want_len;

    assign h = i_frame.hdr;
    assign o_pop = i_avail && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        magic_ok  = h[31:0] == MAGIC_WORD;
        type_ok   = (h[47:40] >= i_cfg.min_msg_kind) &&
                    (h[47:40] <= i_cfg.max_msg_kind);
        ecode_bad = (h[223:208] > i_cfg.max_fault_code) ||
                    ((h[47:40] == i_cfg.fault_msg_kind) ? (h[223:208] == 16'd0)
                                                         : (h[223:208] != 16'd0));
        sum       = h[8*CHECKSUM_OFFSET +: 32];
        want_len  = 18'(HEADER_BYTES) + 18'(h[207:192]);
        n_item    = '0;
        if (i_frame.len < COUNT_W'(HEADER_BYTES)) begin
            n_item.status = ST_SHORT;
        end else begin
            n_item.msg_kind        = h[47:40];
            n_item.flag_bits       = h[63:48];
            n_item.sess_ident      = h[95:64];
            n_item.sequence_number = h[127:96];
            n_item.stamp_usec      = h[191:128];
            n_item.body_len        = h[207:192];
            n_item.fault_code      = h[223:208];
            if (!magic_ok)                                  n_item.status = ST_MAGIC;
            else if (h[39:32] != i_cfg.protocol_version)    n_item.status = ST_VERSION;
            else if (!type_ok)                              n_item.status = ST_TYPE;
            else if ((h[63:48] & ~i_cfg.valid_flags_mask) != 16'd0)
                                                            n_item.status = ST_FLAGS;
            else if (h[207:192] > i_cfg.max_body_len)       n_item.status = ST_LARGE;
            else if (18'(i_frame.len) != want_len)          n_item.status = ST_LENGTH;
            else if (ecode_bad)                             n_item.status = ST_ECODE;
            else if (sum != i_frame.crc)                    n_item.status = ST_CHECKSUM;
            else                                            n_item.status = ST_OK;
            if (magic_ok && type_ok && h[95:64] != 32'd0 && h[127:96] != 32'd0) begin
                case (n_item.status)
                    ST_VERSION: begin
                        n_item.reject_valid = 1'b1;
                        n_item.reject_error = RJ_VERSION;
                    end
                    ST_CHECKSUM: begin
                        n_item.reject_valid = 1'b1;
                        n_item.reject_error = RJ_CHECKSUM;
                    end
                    ST_FLAGS, ST_LARGE, ST_LENGTH, ST_ECODE: begin
                        n_item.reject_valid = 1'b1;
                        n_item.reject_error = RJ_MALFORM;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= n_item;
        end
    end
endmodule

// ----- sv/fchd_checker.sv -----
// fchd_checker: port-level assertions, bound to the top level
// depends on fchd_pkg
module fchd_checker import fchd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input t_out_item o_item,
    input logic      i_stall
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result changed under stall");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.status <= ST_CHECKSUM)
        else $error("status out of range");
    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.reject_valid |-> o_item.reject_error == RJ_VERSION)
        else $error("reject error without reject");
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == ST_SHORT |-> !o_item.reject_valid &&
        o_item.sess_ident == 32'd0)
        else $error("short frame fields not cleared");
endmodule

bind frame_crc_header_decoder_top fchd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .o_item(o_item), .i_stall(i_stall)
);

// ----- tb/sv/testbench.sv -----
// testbench for frame_crc_header_decoder_top: byte-stream frames, predicted header results
// depends on fchd_pkg (types, register and status codes) and the decoder rtl
`timescale 1ns / 100ps
module testbench;
    import fchd_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    t_in_item    i_item;
    logic        o_stall;
    logic        o_valid;
    t_out_item   o_item;
    logic        i_stall;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    frame_crc_header_decoder_top DUT (.*);

    // clock, 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // predictor state, mirrors the block after reset
    t_cfg        cfg_shadow;
    logic [16:0] frame_len;
    logic [31:0] frame_crc;
    logic [7:0]  hdr_bytes [32];
    t_out_item   expected_results [$];

    int  mismatch_count;
    int  error_count;
    bit  no_idle;        // last part of the run: no gaps on either side
    bit  hold_rx;        // long receiver hold-off
    int  hold_rx_cycles;
    int  rx_burst;       // remaining cycles of a short receiver stall burst
    longint cycle_count;

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        return r;
    endfunction

    function automatic logic [31:0] hdr_word(int at);
        return {hdr_bytes[at+3], hdr_bytes[at+2], hdr_bytes[at+1], hdr_bytes[at]};
    endfunction

    // advance the header decoder model by one byte; returns 1 with a result on last
    function automatic bit decode_byte(t_in_item it, output t_out_item res);
        logic [16:0] n;
        logic [31:0] c;
        bit magic_ok, type_ok;
        res = '0;
        if (frame_len < 32) hdr_bytes[frame_len] = it.data_byte;
        frame_crc = crc_step(frame_crc,
            (frame_len >= 28 && frame_len < 32) ? 8'd0 : it.data_byte);
        if (frame_len != 17'h1FFFF) frame_len++;
        if (!it.last_byte) return 0;
        n = frame_len;
        c = ~frame_crc;
        frame_len = '0;
        frame_crc = '1;
        if (n < 32) begin
            res.status = ST_SHORT;
            return 1;
        end
        res.msg_kind        = hdr_bytes[5];
        res.flag_bits       = {hdr_bytes[7], hdr_bytes[6]};
        res.sess_ident      = hdr_word(8);
        res.sequence_number = hdr_word(12);
        res.stamp_usec      = {hdr_word(20), hdr_word(16)};
        res.body_len        = {hdr_bytes[25], hdr_bytes[24]};
        res.fault_code      = {hdr_bytes[27], hdr_bytes[26]};
        magic_ok = hdr_word(0) == MAGIC_WORD;
        type_ok  = res.msg_kind >= cfg_shadow.min_msg_kind &&
                   res.msg_kind <= cfg_shadow.max_msg_kind;
        if (!magic_ok) res.status = ST_MAGIC;
        else if (hdr_bytes[4] != cfg_shadow.protocol_version) res.status = ST_VERSION;
        else if (!type_ok) res.status = ST_TYPE;
        else if ((res.flag_bits & ~cfg_shadow.valid_flags_mask) != 0) res.status = ST_FLAGS;
        else if (res.body_len > cfg_shadow.max_body_len) res.status = ST_LARGE;
        else if (n != 17'd32 + res.body_len) res.status = ST_LENGTH;
        else if (res.fault_code > cfg_shadow.max_fault_code ||
                 ((res.msg_kind == cfg_shadow.fault_msg_kind) ?
                  res.fault_code == 0 : res.fault_code != 0)) res.status = ST_ECODE;
        else if (hdr_word(28) != c) res.status = ST_CHECKSUM;
        else res.status = ST_OK;
        if (magic_ok && type_ok && res.sess_ident != 0 && res.sequence_number != 0) begin
            if (res.status == ST_VERSION) begin
                res.reject_valid = 1'b1;
                res.reject_error = RJ_VERSION;
            end else if (res.status == ST_CHECKSUM) begin
                res.reject_valid = 1'b1;
                res.reject_error = RJ_CHECKSUM;
            end else if (res.status >= ST_FLAGS && res.status <= ST_ECODE) begin
                res.reject_valid = 1'b1;
                res.reject_error = RJ_MALFORM;
            end
        end
        return 1;
    endfunction

    // ---------------- frame builder ----------------
    logic [7:0] frame_buf [$];

    // crc as the block computes it: checksum bytes fed as zero
    function automatic logic [31:0] frame_crc_of();
        logic [31:0] c;
        c = '1;
        foreach (frame_buf[k])
            c = crc_step(c, (k >= 28 && k < 32) ? 8'd0 : frame_buf[k]);
        return ~c;
    endfunction

    // build a well-formed frame (under current config), then optionally break one thing
    task automatic build_frame(int plen, int breakage);
        logic [7:0] mtype;
        logic [15:0] flags, ecode;
        logic [31:0] c;
        frame_buf.delete();
        mtype = (cfg_shadow.min_msg_kind <= cfg_shadow.max_msg_kind) ?
            8'($urandom_range(cfg_shadow.min_msg_kind, cfg_shadow.max_msg_kind)) :
            8'($urandom);
        flags = 16'($urandom) & cfg_shadow.valid_flags_mask;
        if (mtype == cfg_shadow.fault_msg_kind)
            ecode = (cfg_shadow.max_fault_code == 0) ? 16'd1 :
                    16'($urandom_range(1, cfg_shadow.max_fault_code));
        else
            ecode = 16'd0;
        frame_buf = '{8'h49, 8'h56, 8'h43, 8'h31, cfg_shadow.protocol_version, mtype,
                      flags[7:0], flags[15:8]};
        for (int k = 8; k < 24; k++)
            frame_buf.push_back(($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom));
        frame_buf.push_back(plen[7:0]);
        frame_buf.push_back(plen[15:8]);
        frame_buf.push_back(ecode[7:0]);
        frame_buf.push_back(ecode[15:8]);
        repeat (4) frame_buf.push_back(8'd0);
        repeat (plen) frame_buf.push_back(8'($urandom));
        c = frame_crc_of();
        {frame_buf[31], frame_buf[30], frame_buf[29], frame_buf[28]} = c;
        case (breakage)
            0: ;
            1: frame_buf[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            2: frame_buf[4] ^= 8'(1 << $urandom_range(0, 7));
            3: frame_buf[5] = 8'($urandom);
            4: frame_buf[6 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            5: frame_buf[24 + $urandom_range(0, 1)] = 8'($urandom);
            6: frame_buf.push_back(8'($urandom));
            7: frame_buf[26 + $urandom_range(0, 1)] = 8'($urandom);
            8: frame_buf[28 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            9: frame_buf[$urandom_range(32 < frame_buf.size() ? 32 : 8,
                                       frame_buf.size() - 1)] ^= 8'h5A;
            10: while (frame_buf.size() > 31) void'(frame_buf.pop_back());
            default: ;
        endcase
    endtask

    // ---------------- sender ----------------
    task automatic send_byte(logic [7:0] b, bit last);
        t_out_item res;
        // random idle gap bursts on the input
        if (!no_idle && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= '{data_byte: b, last_byte: last};
        do @(posedge i_clk); while (o_stall);
        if (decode_byte('{data_byte: b, last_byte: last}, res))
            expected_results.push_back(res);
    endtask

    task automatic send_frame();
        foreach (frame_buf[k]) send_byte(frame_buf[k], k == frame_buf.size() - 1);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);  // queue and output register plus margin
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_VERSION:    cfg_shadow.protocol_version = val[7:0];
            REG_FLAGS_MASK: cfg_shadow.valid_flags_mask = val;
            REG_MAX_PLEN:   cfg_shadow.max_body_len     = val;
            REG_MIN_TYPE:   cfg_shadow.min_msg_kind     = val[7:0];
            REG_MAX_TYPE:   cfg_shadow.max_msg_kind     = val[7:0];
            REG_ERR_TYPE:   cfg_shadow.fault_msg_kind   = val[7:0];
            REG_MAX_ECODE:  cfg_shadow.max_fault_code   = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // ---------------- result checker ----------------
    task automatic report_mismatch(string what, t_out_item exp_r, t_out_item got);
        mismatch_count++;
        error_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %h got %h", what, exp_r, got);
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", '0, o_item);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_item.status != exp_r.status)
                    report_mismatch("status", exp_r, o_item);
                else if (o_item.msg_kind != exp_r.msg_kind ||
                         o_item.flag_bits != exp_r.flag_bits ||
                         o_item.sess_ident != exp_r.sess_ident ||
                         o_item.sequence_number != exp_r.sequence_number ||
                         o_item.stamp_usec != exp_r.stamp_usec ||
                         o_item.body_len != exp_r.body_len ||
                         o_item.fault_code != exp_r.fault_code)
                    report_mismatch("header fields", exp_r, o_item);
                else if (o_item.reject_valid != exp_r.reject_valid ||
                         o_item.reject_error != exp_r.reject_error)
                    report_mismatch("rejection", exp_r, o_item);
            end
        end
    end

    // receiver stall: short random bursts, or one long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_rx_cycles <= 0;
            rx_burst <= 0;
        end else if (hold_rx) begin
            i_stall <= 1'b1;
            hold_rx_cycles <= hold_rx_cycles + 1;
        end else if (no_idle) begin
            i_stall <= 1'b0;
            rx_burst <= 0;
        end else if (rx_burst != 0) begin
            i_stall <= 1'b1;
            rx_burst <= rx_burst - 1;
        end else if (!i_stall && $urandom_range(0, 9) == 0) begin
            i_stall <= 1'b1;
            rx_burst <= $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // directed rows: expected status typed in where obvious, otherwise predicted
    typedef struct {
        int plen;
        int breakage;
        bit has_exp;
        logic [3:0] exp_status;
    } t_row;

    t_row directed_rows [] = '{
        '{0, 10, 1, ST_SHORT},
        '{0, 0, 1, ST_OK},
        '{4, 0, 1, ST_OK},
        '{2, 1, 1, ST_MAGIC},
        '{2, 2, 1, ST_VERSION},
        '{2, 3, 0, ST_OK},
        '{2, 4, 0, ST_OK},
        '{2, 5, 0, ST_OK},
        '{2, 6, 1, ST_LENGTH},
        '{2, 7, 0, ST_OK},
        '{2, 8, 1, ST_CHECKSUM},
        '{8, 9, 1, ST_CHECKSUM}
    };

    int sent_bytes;

    initial begin
        t_out_item peek;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_VERSION;
        i_cfg_data = '0;
        no_idle = 1'b0;
        hold_rx = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        error_count = 0;
        frame_len = '0;
        frame_crc = '1;
        foreach (hdr_bytes[k]) hdr_bytes[k] = 8'd0;
        cfg_shadow = '{protocol_version: 8'd1, valid_flags_mask: 16'd1,
                       max_body_len: 16'd1024, min_msg_kind: 8'd1,
                       max_msg_kind: 8'd8, fault_msg_kind: 8'd4,
                       max_fault_code: 16'd16};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under reset config, then under wide config
        for (int pass = 0; pass < 2; pass++) begin
            foreach (directed_rows[r]) begin
                build_frame(directed_rows[r].plen, directed_rows[r].breakage);
                send_frame();
                if (directed_rows[r].has_exp) begin
                    peek = expected_results[$];
                    if (peek.status != directed_rows[r].exp_status) begin
                        error_count++;
                        $display("row %0d: model status %0d, table says %0d",
                                 r, peek.status, directed_rows[r].exp_status);
                    end
                end
            end
            drain();
            if (pass == 0) begin
                write_reg(REG_VERSION, 16'h00FF);
                write_reg(REG_FLAGS_MASK, 16'hFFFF);
                write_reg(REG_MAX_PLEN, 16'd40);
                write_reg(REG_MIN_TYPE, 16'd0);
                write_reg(REG_MAX_TYPE, 16'd255);
                write_reg(REG_ERR_TYPE, 16'd255);
                write_reg(REG_MAX_ECODE, 16'hFFFF);
            end
        end

        // pure noise frame with all bytes 0xff, and an all-zero header
        frame_buf.delete();
        repeat (40) frame_buf.push_back(8'hFF);
        send_frame();
        frame_buf.delete();
        repeat (32) frame_buf.push_back(8'h00);
        send_frame();
        drain();

        // random phases over several config settings
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_VERSION, 16'd0);
                    write_reg(REG_FLAGS_MASK, 16'h0000);
                    write_reg(REG_MAX_PLEN, 16'd0);
                    write_reg(REG_MIN_TYPE, 16'd0);
                    write_reg(REG_MAX_TYPE, 16'd0);
                    write_reg(REG_ERR_TYPE, 16'd0);
                    write_reg(REG_MAX_ECODE, 16'd0);
                end
                1: begin
                    // inverted type range
                    write_reg(REG_MIN_TYPE, 16'd9);
                    write_reg(REG_MAX_TYPE, 16'd3);
                    write_reg(REG_MAX_PLEN, 16'hFFFF);
                end
                4: begin
                    write_reg(REG_VERSION, 16'($urandom));
                    write_reg(REG_FLAGS_MASK, 16'($urandom));
                    write_reg(REG_MAX_PLEN, 16'($urandom_range(0, 24)));
                    write_reg(REG_MIN_TYPE, 16'($urandom_range(0, 100)));
                    write_reg(REG_MAX_TYPE, 16'($urandom_range(100, 255)));
                    write_reg(REG_ERR_TYPE, 16'($urandom_range(0, 255)));
                    write_reg(REG_MAX_ECODE, 16'($urandom));
                end
                default: begin
                    write_reg(REG_VERSION, 16'($urandom_range(0, 255)));
                    write_reg(REG_FLAGS_MASK, 16'($urandom));
                    write_reg(REG_MAX_PLEN, 16'($urandom_range(0, 16)));
                    write_reg(REG_MIN_TYPE, 16'($urandom_range(0, 10)));
                    write_reg(REG_MAX_TYPE, 16'($urandom_range(10, 255)));
                    write_reg(REG_ERR_TYPE, 16'($urandom_range(0, 20)));
                    write_reg(REG_MAX_ECODE, 16'($urandom_range(1, 65535)));
                end
            endcase
            if (phase == 4) no_idle = 1'b1;  // last part of the run runs flat out
            sent_bytes = 0;
            while (sent_bytes < 30) begin
                // receiver hold-off while sender keeps pushing until the input stalls
                if (phase == 2 && sent_bytes == 0) begin
                    hold_rx = 1'b1;
                    fork
                        begin
                            repeat (5) begin
                                build_frame(0, $urandom_range(0, 9));
                                send_frame();
                            end
                        end
                        begin
                            wait (hold_rx_cycles >= 150);
                            hold_rx = 1'b0;
                        end
                    join
                    sent_bytes += 160;
                end
                if ($urandom_range(0, 4) == 0) begin
                    // noise frame of random length, sometimes short
                    frame_buf.delete();
                    repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom));
                    if ($urandom_range(0, 1)) begin
                        frame_buf[0] = 8'h49;
                        if (frame_buf.size() > 3) begin
                            frame_buf[1] = 8'h56;
                            frame_buf[2] = 8'h43;
                            frame_buf[3] = 8'h31;
                        end
                    end
                end else begin
                    build_frame((cfg_shadow.max_body_len > 12) ? $urandom_range(0, 12) :
                                $urandom_range(0, cfg_shadow.max_body_len),
                                ($urandom_range(0, 1)) ? 0 : $urandom_range(1, 10));
                end
                sent_bytes += frame_buf.size();
                send_frame();
                if (phase == 3) begin
                    // sender pauses until every result is back
                    i_valid <= 1'b0;
                    while (expected_results.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // leftover expectations at the watchdog limit count as failures
    always @(posedge i_clk) begin
        if (cycle_count == 400000 && expected_results.size() != 0) error_count++;
    end
endmodule

// ----- frame_crc_header_decoder_top.f -----
sv/fchd_pkg.sv
sv/fchd_front.sv
sv/fchd_queue.sv
sv/fchd_back.sv
sv/frame_crc_header_decoder_top.sv
sv/fchd_checker.sv
tb/sv/testbench.sv
